// ----- hdl/pisf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pisf_pkg
// Shared types, codes and defaults of the soft-start PI gate regulator.
// ----------------------------------------------------------------------------
package pisf_pkg;

	localparam int unsigned GATE_W  = 12;
	localparam int unsigned GAIN_W  = 17;
	localparam int unsigned CNT_W   = 7;
	localparam int unsigned INDEX_W = 8;

	localparam int unsigned FAULT_TICKS_DEF = 100;
	localparam int unsigned RAMP_STEP_DEF   = 8;
	localparam int unsigned SAT_MARGIN_DEF  = 32;
	localparam int unsigned FRAC_BITS_DEF   = 8;

	localparam logic [GATE_W-1:0] GATE_OFF = 12'hFFF;
	localparam logic [GAIN_W-1:0] GAIN_MAX = 17'h10000;
	localparam logic [GAIN_W-1:0] KI_RESET = 17'd13107;
	localparam logic [GAIN_W-1:0] KP_RESET = 17'd8192;
	localparam logic [CNT_W-1:0]  CNT_MAX  = 7'd127;

	// Configuration register indexes.
	localparam logic [INDEX_W-1:0] REG_TARGET = 8'd0;
	localparam logic [INDEX_W-1:0] REG_PASS   = 8'd1;
	localparam logic [INDEX_W-1:0] REG_KI     = 8'd2;
	localparam logic [INDEX_W-1:0] REG_KP     = 8'd3;

	typedef enum logic [1:0] {
		OP_TICK   = 2'd0,
		OP_START  = 2'd1,
		OP_STOP   = 2'd2,
		OP_WINDOW = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		MODE_OFF   = 3'd0,
		MODE_SOFT  = 3'd1,
		MODE_ON    = 3'd2,
		MODE_PASS  = 3'd3,
		MODE_FAULT = 3'd4
	} mode_t;

	typedef struct packed {
		op_t               op;
		logic [GATE_W-1:0] sample;
		logic              wd;
	} item_t;

	typedef struct packed {
		logic [GATE_W-1:0] target;
		logic              pass_req;
		logic [GAIN_W-1:0] ki;
		logic [GAIN_W-1:0] kp;
	} cfg_t;

	typedef struct packed {
		logic [GATE_W-1:0] gate;
		mode_t             mode;
		logic [GATE_W-1:0] win_min;
		logic [GATE_W-1:0] win_max;
	} res_t;

endpackage

// ----- hdl/pisf_cfg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pisf_cfg
// Configuration register file with gain saturation on write.
// ----------------------------------------------------------------------------
module pisf_cfg
	import pisf_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  logic [INDEX_W-1:0] wr_index,
	input  logic [GAIN_W-1:0]  wr_data,
	output cfg_t               cfg
);

	cfg_t              cfg_q;
	logic [GAIN_W-1:0] gain_sat;

	// Gains above unity are clipped to unity.
	assign gain_sat = (wr_data > GAIN_MAX) ? GAIN_MAX : wr_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target   <= '0;
			cfg_q.pass_req <= 1'b0;
			cfg_q.ki       <= KI_RESET;
			cfg_q.kp       <= KP_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_TARGET: cfg_q.target   <= wr_data[GATE_W-1:0];
				REG_PASS:   cfg_q.pass_req <= wr_data[0];
				REG_KI:     cfg_q.ki       <= gain_sat;
				REG_KP:     cfg_q.kp       <= gain_sat;
				default:    ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- hdl/pisf_pi.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pisf_pi
// One PI step: clamped integrator update and clamped P+I output.
// ----------------------------------------------------------------------------
module pisf_pi
	import pisf_pkg::*;
#(
	parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic [GATE_W-1:0]           setpoint,
	input  logic [GATE_W-1:0]           sample,
	input  logic [GATE_W+FRAC_BITS-1:0] integ,
	input  logic [GAIN_W-1:0]           ki,
	input  logic [GAIN_W-1:0]           kp,
	output logic [GATE_W+FRAC_BITS-1:0] integ_new,
	output logic [GATE_W-1:0]           gate_new
);

	localparam int unsigned IW = GATE_W + FRAC_BITS;
	localparam int unsigned EW = GATE_W + 1;
	localparam int unsigned PW = EW + GAIN_W + 1;
	localparam int unsigned SW = ((PW > IW) ? PW : IW) + 2;
	localparam logic [IW-1:0]        INTEG_TOP = IW'(GATE_OFF) << FRAC_BITS;
	localparam logic signed [SW-1:0] TOP_S     = SW'(INTEG_TOP);

	logic signed [EW-1:0]       err;
	logic signed [GAIN_W:0]     ki_s;
	logic signed [GAIN_W:0]     kp_s;
	logic signed [PW-1:0]       prod_i;
	logic signed [PW-1:0]       prod_p;
	logic signed [SW-1:0]       acc;
	logic signed [SW-1:0]       acc_c;
	logic signed [SW-1:0]       out_v;
	logic signed [SW-1:0]       out_c;

	assign err  = signed'({1'b0, setpoint}) - signed'({1'b0, sample});
	assign ki_s = signed'({1'b0, ki});
	assign kp_s = signed'({1'b0, kp});

	assign prod_i = err * ki_s;
	assign prod_p = err * kp_s;

	// The arithmetic shift rounds toward minus infinity.
	assign acc = signed'(SW'(integ)) - SW'(prod_i >>> FRAC_BITS);

	always_comb begin
		if (acc < 0) begin
			acc_c = '0;
		end else if (acc > TOP_S) begin
			acc_c = TOP_S;
		end else begin
			acc_c = acc;
		end
	end

	assign out_v = acc_c - SW'(prod_p >>> FRAC_BITS);

	always_comb begin
		if (out_v < 0) begin
			out_c = '0;
		end else if (out_v > TOP_S) begin
			out_c = TOP_S;
		end else begin
			out_c = out_v;
		end
	end

	assign integ_new = acc_c[IW-1:0];
	assign gate_new  = out_c[FRAC_BITS +: GATE_W];

endmodule

// ----- hdl/pisf_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pisf_ctrl
// Regulator state: mode sequencing, soft-start ramp, fault latch, min/max
// window and the PI loop state. Applies one word per enabled cycle.
// ----------------------------------------------------------------------------
module pisf_ctrl
	import pisf_pkg::*;
#(
	parameter int unsigned FAULT_TICKS = FAULT_TICKS_DEF,
	parameter int unsigned RAMP_STEP   = RAMP_STEP_DEF,
	parameter int unsigned SAT_MARGIN  = SAT_MARGIN_DEF,
	parameter int unsigned FRAC_BITS   = FRAC_BITS_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  item_t item,
	input  cfg_t  cfg,
	output res_t  res
);

	localparam int unsigned IW = GATE_W + FRAC_BITS;
	localparam logic [IW-1:0] INTEG_TOP = IW'(GATE_OFF) << FRAC_BITS;

	mode_t             mode_q, mode_d;
	logic [GATE_W-1:0] setpoint_q, setpoint_d;
	logic [IW-1:0]     integ_q, integ_d;
	logic [GATE_W-1:0] gate_q, gate_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	logic [GATE_W-1:0] win_min_q, win_min_d;
	logic [GATE_W-1:0] win_max_q, win_max_d;

	logic              is_tick;
	logic              active;
	logic              wd_sat;
	logic [CNT_W-1:0]  cnt_inc;
	logic              trip;
	logic [GATE_W:0]   ramp_sum;
	logic              ramp_done;
	logic              pi_run;
	logic [GATE_W-1:0] sp_pi;
	logic [IW-1:0]     pi_integ;
	logic [GATE_W-1:0] pi_gate;

	assign is_tick   = (item.op == OP_TICK);
	assign active    = (mode_q == MODE_ON) || (mode_q == MODE_PASS);
	assign wd_sat    = item.wd && (gate_q <= GATE_W'(SAT_MARGIN));
	assign cnt_inc   = (cnt_q == CNT_MAX) ? CNT_MAX : cnt_q + 1'b1;
	assign trip      = is_tick && active && wd_sat && (cnt_inc >= CNT_W'(FAULT_TICKS));
	assign ramp_sum  = {1'b0, setpoint_q} + (GATE_W + 1)'(RAMP_STEP);
	assign ramp_done = ramp_sum >= {1'b0, cfg.target};

	// During the ramp the loop already tracks the new setpoint.
	assign sp_pi = (mode_q != MODE_SOFT) ? setpoint_q :
	               ramp_done ? cfg.target : ramp_sum[GATE_W-1:0];

	assign pi_run = is_tick &&
	                (((mode_q == MODE_ON) && !trip) ||
	                 ((mode_q == MODE_SOFT) && !(ramp_done && cfg.pass_req)));

	pisf_pi #(
		.FRAC_BITS (FRAC_BITS)
	) u_pi (
		.setpoint  (sp_pi),
		.sample    (item.sample),
		.integ     (integ_q),
		.ki        (cfg.ki),
		.kp        (cfg.kp),
		.integ_new (pi_integ),
		.gate_new  (pi_gate)
	);

	// Next mode.
	always_comb begin
		mode_d = mode_q;
		if (en) begin
			unique case (item.op)
				OP_TICK: begin
					if (trip) begin
						mode_d = MODE_FAULT;
					end else if ((mode_q == MODE_SOFT) && ramp_done) begin
						mode_d = cfg.pass_req ? MODE_PASS : MODE_ON;
					end
				end
				OP_START:  mode_d = MODE_SOFT;
				OP_STOP:   mode_d = MODE_OFF;
				OP_WINDOW: mode_d = mode_q;
			endcase
		end
	end

	// Next datapath state.
	always_comb begin
		setpoint_d = setpoint_q;
		integ_d    = integ_q;
		gate_d     = gate_q;
		cnt_d      = cnt_q;
		win_min_d  = win_min_q;
		win_max_d  = win_max_q;
		if (en) begin
			unique case (item.op)
				OP_TICK: begin
					if (active) begin
						if (item.sample < win_min_q) begin
							win_min_d = item.sample;
						end
						if (item.sample > win_max_q) begin
							win_max_d = item.sample;
						end
						cnt_d = wd_sat ? cnt_inc : '0;
					end
					if (trip) begin
						gate_d  = GATE_OFF;
						integ_d = INTEG_TOP;
					end else if (mode_q == MODE_SOFT) begin
						setpoint_d = sp_pi;
						if (ramp_done) begin
							cnt_d = '0;
							if (cfg.pass_req) begin
								gate_d  = '0;
								integ_d = '0;
							end
						end
					end
					if (pi_run) begin
						gate_d  = pi_gate;
						integ_d = pi_integ;
					end
				end
				OP_START: begin
					if ((mode_q == MODE_OFF) || (mode_q == MODE_FAULT) ||
					    (mode_q == MODE_PASS)) begin
						gate_d  = GATE_OFF;
						integ_d = INTEG_TOP;
					end
					setpoint_d = (item.sample < cfg.target) ? item.sample : cfg.target;
					win_min_d  = item.sample;
					win_max_d  = item.sample;
				end
				OP_STOP: begin
					gate_d  = GATE_OFF;
					integ_d = INTEG_TOP;
				end
				OP_WINDOW: begin
					win_min_d = item.sample;
					win_max_d = item.sample;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_OFF;
			setpoint_q <= '0;
			integ_q    <= INTEG_TOP;
			gate_q     <= GATE_OFF;
			cnt_q      <= '0;
			win_min_q  <= '0;
			win_max_q  <= '0;
		end else begin
			mode_q     <= mode_d;
			setpoint_q <= setpoint_d;
			integ_q    <= integ_d;
			gate_q     <= gate_d;
			cnt_q      <= cnt_d;
			win_min_q  <= win_min_d;
			win_max_q  <= win_max_d;
		end
	end

	// The result reflects the state after the word has been applied.
	assign res.gate    = gate_d;
	assign res.mode    = mode_d;
	assign res.win_min = win_min_d;
	assign res.win_max = win_max_d;

endmodule

// ----- hdl/pi_regulator_softstart_fault.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pi_regulator_softstart_fault
// Inverted-gate PI regulator with soft-start ramp, pass-through mode,
// short-circuit fault latch and min/max sample window.
// ----------------------------------------------------------------------------
//  channel  direction  handshake           payload
//  s_*      in         s_tvalid/s_tready   tuser operation, tdata sample+flag
//  m_*      out        m_tvalid/m_tready   tdata gate, mode, min, max
//  cfg_*    in         cfg_valid/cfg_ready register index and write data
//
// Every input word produces one output word: the word is accepted into the input
// register, and the PI step writes the output register when the word advances.
// A word is taken in every cycle while the output side keeps up.
// When m_tready is low the output register holds and one more word waits in
// the input register. Reset restores the idle state and the default gains.
// ----------------------------------------------------------------------------
module pi_regulator_softstart_fault
	import pisf_pkg::*;
#(
	parameter int unsigned FAULT_TICKS = FAULT_TICKS_DEF,
	parameter int unsigned RAMP_STEP   = RAMP_STEP_DEF,
	parameter int unsigned SAT_MARGIN  = SAT_MARGIN_DEF,
	parameter int unsigned FRAC_BITS   = FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [15:0]        s_tdata,   // [11:0] sample, [12] watchdog_flag
	input  logic [1:0]         s_tuser,   // [1:0] operation
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [39:0]        m_tdata,   // [11:0] gate_code, [14:12] mode,
	                                      // [26:15] min_sample, [38:27] max_sample
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [INDEX_W-1:0] cfg_index,
	input  logic [GAIN_W-1:0]  cfg_data
);

	item_t item_s1;
	logic  valid_s1;
	logic  advance;
	cfg_t  cfg;
	res_t  res;
	res_t  res_s2;

	assign cfg_ready = 1'b1;

	pisf_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	assign advance  = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.op     <= op_t'(s_tuser);
			item_s1.sample <= s_tdata[GATE_W-1:0];
			item_s1.wd     <= s_tdata[GATE_W];
		end
	end

	pisf_ctrl #(
		.FAULT_TICKS (FAULT_TICKS),
		.RAMP_STEP   (RAMP_STEP),
		.SAT_MARGIN  (SAT_MARGIN),
		.FRAC_BITS   (FRAC_BITS)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (advance) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign m_tdata = {1'b0, res_s2.win_max, res_s2.win_min, res_s2.mode, res_s2.gate};

endmodule

// ----- tb/pi_regulator_softstart_fault_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pi_regulator_softstart_fault_tb
// Self-checking bench for the soft-start PI gate regulator. A scoreboard
// class tracks the regulator state and predicts the status word for every
// accepted input word. Stimulus is a short directed pass followed by
// start/regulate/shutdown runs, fault runs that hold the watchdog flag and
// random noise. Configuration changes between runs, under four idling phases.
// ----------------------------------------------------------------------------
module pi_regulator_softstart_fault_tb;
	import pisf_pkg::*;

	class gate_scoreboard;
		int    target;
		int    pass_req;
		int    ki;
		int    kp;
		mode_t mode;
		int    setpoint;
		longint integ;
		int    gate;
		int    fault_cnt;
		int    win_lo;
		int    win_hi;
		res_t  pending_status[$];
		int    errors;

		function new();
			target    = 0;
			pass_req  = 0;
			ki        = int'(KI_RESET);
			kp        = int'(KP_RESET);
			mode      = MODE_OFF;
			setpoint  = 0;
			park(int'(GATE_OFF));
			fault_cnt = 0;
			win_lo    = 0;
			win_hi    = 0;
			errors    = 0;
		endfunction

		function void park(int code);
			gate  = code;
			integ = longint'(code) << FRAC_BITS_DEF;
		endfunction

		function longint clip_to_gate(longint x);
			longint top;
			top = longint'(GATE_OFF) << FRAC_BITS_DEF;
			if (x < 0)
				return 0;
			if (x > top)
				return top;
			return x;
		endfunction

		function void write_reg(logic [INDEX_W-1:0] idx, int value);
			case (idx)
				REG_TARGET: target = value & 'hFFF;
				REG_PASS:   pass_req = value & 1;
				REG_KI:     ki = (value > int'(GAIN_MAX)) ? int'(GAIN_MAX) : value;
				REG_KP:     kp = (value > int'(GAIN_MAX)) ? int'(GAIN_MAX) : value;
				default: ;
			endcase
		endfunction

		function void take_item(op_t op, int v, bit wd);
			longint e;
			longint outv;
			res_t   word;
			case (op)
				OP_TICK: begin
					if (mode == MODE_ON || mode == MODE_PASS) begin
						if (v < win_lo)
							win_lo = v;
						if (v > win_hi)
							win_hi = v;
						if (wd && gate <= SAT_MARGIN_DEF) begin
							if (fault_cnt < int'(CNT_MAX))
								fault_cnt++;
							if (fault_cnt >= FAULT_TICKS_DEF) begin
								park(int'(GATE_OFF));
								mode = MODE_FAULT;
							end
						end else begin
							fault_cnt = 0;
						end
					end
					// End of the ramp either parks the gate fully on or hands over to PI.
					if (mode == MODE_SOFT) begin
						if (setpoint + RAMP_STEP_DEF >= target) begin
							setpoint  = target;
							fault_cnt = 0;
							if (pass_req) begin
								park(0);
								mode = MODE_PASS;
							end else begin
								mode = MODE_ON;
							end
						end else begin
							setpoint = setpoint + RAMP_STEP_DEF;
						end
					end
					if (mode == MODE_SOFT || mode == MODE_ON) begin
						e     = longint'(setpoint) - longint'(v);
						integ = clip_to_gate(integ - ((e * ki) >>> FRAC_BITS_DEF));
						outv  = clip_to_gate(integ - ((e * kp) >>> FRAC_BITS_DEF));
						gate  = int'(outv >>> FRAC_BITS_DEF) & 'hFFF;
					end
				end
				OP_START: begin
					if (mode == MODE_OFF || mode == MODE_FAULT || mode == MODE_PASS)
						park(int'(GATE_OFF));
					setpoint = (v < target) ? v : target;
					win_lo   = v;
					win_hi   = v;
					mode     = MODE_SOFT;
				end
				OP_STOP: begin
					mode = MODE_OFF;
					park(int'(GATE_OFF));
				end
				default: begin
					win_lo = v;
					win_hi = v;
				end
			endcase
			word.gate    = gate[GATE_W-1:0];
			word.mode    = mode;
			word.win_min = win_lo[GATE_W-1:0];
			word.win_max = win_hi[GATE_W-1:0];
			pending_status.push_back(word);
		endfunction

		function void compare(string field, logic [GATE_W-1:0] want, logic [GATE_W-1:0] got);
			if (want !== got) begin
				errors++;
				$display("%0t: %s expected %0d actual %0d", $time, field, want, got);
			end
		endfunction

		function void check_status(logic [39:0] word);
			res_t want;
			if (pending_status.size() == 0) begin
				errors++;
				$display("%0t: status word %h with none expected", $time, word);
				return;
			end
			want = pending_status.pop_front();
			compare("gate_code", want.gate, word[11:0]);
			compare("mode", GATE_W'(want.mode), GATE_W'(word[14:12]));
			compare("min_sample", want.win_min, word[26:15]);
			compare("max_sample", want.win_max, word[38:27]);
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [15:0]        s_tdata = '0;   // [11:0] sample, [12] watchdog_flag
	logic [1:0]         s_tuser = '0;   // [1:0] operation
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [39:0]        m_tdata;        // [11:0] gate, [14:12] mode, [26:15] min, [38:27] max
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [INDEX_W-1:0] cfg_index = '0;
	logic [GAIN_W-1:0]  cfg_data = '0;

	gate_scoreboard sb = new();
	int send_idle_pct = 0;
	int stall_pct = 0;
	int items_sent = 0;

	pi_regulator_softstart_fault DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(negedge clk) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else
			m_tready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_status(m_tdata);
	end

	task automatic send_item(op_t op, int v, bit wd);
		@(negedge clk);
		if ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {3'b000, wd, v[GATE_W-1:0]};
		do @(posedge clk); while (!s_tready);
		sb.take_item(op, v, wd);
		items_sent++;
	endtask

	// Stops sending and waits for every outstanding status word.
	task automatic drain();
		int waited;
		waited = 0;
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (sb.pending_status.size() != 0 && waited < 5000) begin
			@(posedge clk);
			waited++;
		end
	endtask

	task automatic write_reg(logic [INDEX_W-1:0] idx, int value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value[GAIN_W-1:0];
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, value);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic int near_target(int lo_off, int hi_off);
		int v;
		v = sb.target + $urandom_range(lo_off + hi_off) - lo_off;
		if (v < 0)
			v = 0;
		if (v > 4095)
			v = 4095;
		return v;
	endfunction

	task automatic regulation_run();
		int len;
		int pick;
		len = $urandom_range(10, 40);
		if ($urandom_range(9) == 0)
			send_item(OP_START, $urandom_range(4095), 1'($urandom_range(1)));
		else
			send_item(OP_START, near_target(64, 0), 1'($urandom_range(1)));
		repeat (len) begin
			pick = $urandom_range(99);
			if (pick < 5)
				send_item(OP_WINDOW, near_target(300, 300), 1'($urandom_range(1)));
			else if (pick < 8)
				send_item(OP_START, near_target(100, 100), 1'($urandom_range(1)));
			else if (pick < 80)
				send_item(OP_TICK, near_target(300, 300), $urandom_range(9) == 0);
			else
				send_item(OP_TICK, $urandom_range(4095), $urandom_range(9) == 0);
		end
		if ($urandom_range(1))
			send_item(OP_STOP, $urandom_range(4095), 1'($urandom_range(1)));
	endtask

	// Drives the gate into saturation, then holds the watchdog flag for at least
	// FAULT_TICKS_DEF ticks so that the fault can latch. A broken run drops the flag now and then.
	task automatic fault_run(bit broken);
		int n;
		bit wd;
		send_item(OP_START, near_target(16, 0), 1'b0);
		repeat ($urandom_range(3, 12))
			send_item(OP_TICK, $urandom_range(sb.target / 4), 1'b0);
		n = $urandom_range(100, 106);
		for (int i = 0; i < n; i++) begin
			wd = !(broken && $urandom_range(29) == 0);
			send_item(OP_TICK, $urandom_range(sb.target / 4), wd);
		end
		repeat ($urandom_range(1, 4))
			send_item(OP_TICK, $urandom_range(4095), 1'($urandom_range(1)));
		case ($urandom_range(2))
			0: send_item(OP_START, near_target(16, 0), 1'b1);
			1: send_item(OP_STOP, $urandom_range(4095), 1'b1);
			default: send_item(OP_WINDOW, $urandom_range(4095), 1'b0);
		endcase
	endtask

	task automatic noise_burst();
		repeat ($urandom_range(5, 15))
			send_item(op_t'($urandom_range(3)), $urandom_range(4095), 1'($urandom_range(1)));
	endtask

	initial begin
		int phase_end;
		int pick;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed pass, no idling.
		write_reg(REG_TARGET, 100);
		write_reg(8'd4, 'h1FFFF);
		write_reg(8'd255, 0);
		send_item(OP_TICK, 4095, 1'b1);
		send_item(OP_WINDOW, 4095, 1'b0);
		send_item(OP_STOP, 0, 1'b1);
		send_item(OP_START, 4095, 1'b0);
		send_item(OP_TICK, 0, 1'b0);
		send_item(OP_TICK, 4095, 1'b1);
		send_item(OP_WINDOW, 0, 1'b0);
		send_item(OP_TICK, 50, 1'b0);
		send_item(OP_START, 0, 1'b0);
		send_item(OP_TICK, 0, 1'b0);
		send_item(OP_TICK, 0, 1'b1);
		send_item(OP_TICK, 4095, 1'b0);
		send_item(OP_STOP, 4095, 1'b0);
		drain();
		write_reg(REG_PASS, 'h1FFFF);
		send_item(OP_START, 95, 1'b0);
		send_item(OP_TICK, 200, 1'b1);
		send_item(OP_TICK, 4095, 1'b1);
		send_item(OP_TICK, 0, 1'b0);
		send_item(OP_WINDOW, 77, 1'b1);
		send_item(OP_START, 100, 1'b0);
		send_item(OP_TICK, 100, 1'b0);
		send_item(OP_STOP, 0, 1'b0);

		for (int p = 0; p < 4; p++) begin
			drain();
			case (p)
				0: begin
					send_idle_pct = 0;
					stall_pct     = 0;
					write_reg(REG_TARGET, 4095);
					write_reg(REG_PASS, 0);
					write_reg(REG_KI, int'(KI_RESET));
					write_reg(REG_KP, int'(KP_RESET));
				end
				1: begin
					send_idle_pct = 62;
					stall_pct     = 0;
					write_reg(REG_TARGET, 0);
					write_reg(REG_PASS, 1);
					write_reg(REG_KI, 65536);
					write_reg(REG_KP, 0);
				end
				2: begin
					send_idle_pct = 0;
					stall_pct     = 62;
					write_reg(REG_TARGET, $urandom_range(4095));
					write_reg(REG_PASS, 0);
					write_reg(REG_KI, 'h1FFFF);
					write_reg(REG_KP, 65536);
				end
				default: begin
					send_idle_pct = 20;
					stall_pct     = 20;
					write_reg(REG_TARGET, 'h1F800);
					write_reg(REG_PASS, 1);
					write_reg(REG_KI, 0);
					write_reg(REG_KP, 100000);
				end
			endcase
			phase_end = items_sent + 256;
			if (p == 1)
				write_reg(REG_TARGET, 2000);
			fault_run(p[0]);
			while (items_sent < phase_end) begin
				pick = $urandom_range(99);
				if (pick < 20) begin
					drain();
					if ($urandom_range(9) == 0)
						write_reg(INDEX_W'($urandom_range(4, 255)), $urandom_range('h1FFFF));
					else
						write_reg(INDEX_W'($urandom_range(3)), $urandom_range('h1FFFF));
				end else if (pick < 80) begin
					regulation_run();
				end else begin
					noise_burst();
				end
			end
		end

		drain();
		repeat (4) @(posedge clk);
		if (sb.pending_status.size() != 0) begin
			sb.errors++;
			$display("%0t: %0d status words never arrived", $time, sb.pending_status.size());
		end
		if (sb.errors == 0)
			$display("pi_regulator_softstart_fault test passed");
		else
			$display("pi_regulator_softstart_fault test failed");
		$finish;
	end

	initial begin
		#2000000;
		$display("pi_regulator_softstart_fault test failed");
		$finish;
	end

endmodule

// ----- files.f -----
hdl/pisf_pkg.sv
hdl/pisf_cfg.sv
hdl/pisf_pi.sv
hdl/pisf_ctrl.sv
hdl/pi_regulator_softstart_fault.sv
tb/pi_regulator_softstart_fault_tb.sv
